// File: hdl/kdc_pkg.sv
// Shared types and constants for the keypad decimal calculator.
package kdc_pkg;

  localparam int unsigned MaxDigits = 4;
  localparam int unsigned DataW     = 16;
  localparam int unsigned CountW    = 3;
  localparam int unsigned StepCount = DataW;
  localparam int unsigned StepW     = $clog2(StepCount);

  typedef enum logic [2:0] {
    KEY_DIGIT = 3'd0,
    KEY_ADD   = 3'd1,
    KEY_SUB   = 3'd2,
    KEY_MUL   = 3'd3,
    KEY_DIV   = 3'd4,
    KEY_EQ    = 3'd5,
    KEY_CLEAR = 3'd6
  } key_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_OFF    = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_CALC = 2'd1,
    CS_WAIT = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] digit_value;
  } key_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             divide_error;
  } result_t;

  typedef struct packed {
    logic clear;
    logic app_first;
    logic app_second;
    logic set_op;
    op_e  op;
    logic start;
    logic step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
  } dp_stat_t;

endpackage

// File: hdl/kdc_ctrl.sv
// Controller: calculator phase and the sequencer for the iterative multiply and divide.
module kdc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  kdc_pkg::key_t  key_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output kdc_pkg::dp_cmd_t cmd_o,
  input  kdc_pkg::dp_stat_t stat_i
);
  import kdc_pkg::*;

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  assign in_ready_o  = (state_q == CS_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      phase_q     <= PH_OFF;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.op = op_e'(2'(key_i.command - 3'd1));
    unique case (state_q)
      CS_IDLE: begin
        if (accept) begin
          if (key_e'(key_i.command) == KEY_CLEAR) begin
            cmd_o.clear = 1'b1;
            phase_d     = PH_FIRST;
          end else begin
            unique case (phase_q)
              PH_FIRST: begin
                case (key_e'(key_i.command)) inside
                  KEY_DIGIT: cmd_o.app_first = 1'b1;
                  KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
                    cmd_o.set_op = 1'b1;
                    phase_d      = PH_SECOND;
                  end
                  default: ;
                endcase
              end
              PH_SECOND: begin
                case (key_e'(key_i.command)) inside
                  KEY_DIGIT: cmd_o.app_second = 1'b1;
                  KEY_EQ: begin
                    cmd_o.start = 1'b1;
                    phase_d     = PH_DONE;
                    state_d     = CS_CALC;
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
      end
      CS_CALC: begin
        cmd_o.step = 1'b1;
        if (stat_i.last_step) begin
          state_d = CS_WAIT;
        end
      end
      CS_WAIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
    out_valid_d = cmd_o.load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

endmodule

// File: hdl/kdc_dp.sv
// Datapath: operand entry, shift-add multiplier, restoring divider and result register.
module kdc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kdc_pkg::dp_cmd_t  cmd_i,
  input  kdc_pkg::key_t     key_i,
  output kdc_pkg::dp_stat_t stat_o,
  output kdc_pkg::result_t  result_o
);
  import kdc_pkg::*;

  logic [DataW-1:0]  first_q, first_d, second_q, second_d;
  logic [CountW-1:0] first_cnt_q, first_cnt_d, second_cnt_q, second_cnt_d;
  op_e               op_q, op_d;
  logic [DataW-1:0]  wa_q, wa_d, wb_q, wb_d;
  logic [DataW:0]    acc_q, acc_d;
  logic [StepW-1:0]  step_q, step_d;
  result_t           res_q, res_d;

  logic              digit_ok;
  logic [DataW-1:0]  first_app, second_app;
  logic [DataW:0]    rem_sh;
  logic [DataW+1:0]  diff;

  assign digit_ok   = (key_i.digit_value <= 4'd9);
  assign first_app  = {first_q[DataW-4:0], 3'b000} + {first_q[DataW-2:0], 1'b0}
                      + DataW'(key_i.digit_value);
  assign second_app = {second_q[DataW-4:0], 3'b000} + {second_q[DataW-2:0], 1'b0}
                      + DataW'(key_i.digit_value);
  assign rem_sh     = {acc_q[DataW-1:0], wa_q[DataW-1]};
  assign diff       = {1'b0, rem_sh} - {2'b00, second_q};

  assign stat_o.last_step = (step_q == StepW'(StepCount - 1));
  assign result_o         = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= '0;
      second_q     <= '0;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      op_q         <= OP_ADD;
      step_q       <= '0;
    end else begin
      first_q      <= first_d;
      second_q     <= second_d;
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      op_q         <= op_d;
      step_q       <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q  <= wa_d;
    wb_q  <= wb_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  always_comb begin
    first_d      = first_q;
    second_d     = second_q;
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    op_d         = op_q;
    wa_d         = wa_q;
    wb_d         = wb_q;
    acc_d        = acc_q;
    step_d       = step_q;
    res_d        = res_q;

    if (cmd_i.clear) begin
      first_d      = '0;
      second_d     = '0;
      first_cnt_d  = '0;
      second_cnt_d = '0;
      op_d         = OP_ADD;
    end
    if (cmd_i.app_first && digit_ok && (first_cnt_q < CountW'(MaxDigits))) begin
      first_d     = first_app;
      first_cnt_d = first_cnt_q + 1'b1;
    end
    if (cmd_i.app_second && digit_ok && (second_cnt_q < CountW'(MaxDigits))) begin
      second_d     = second_app;
      second_cnt_d = second_cnt_q + 1'b1;
    end
    if (cmd_i.set_op) begin
      op_d = cmd_i.op;
    end

    if (cmd_i.start) begin
      wa_d   = first_q;
      wb_d   = second_q;
      acc_d  = '0;
      step_d = '0;
    end
    if (cmd_i.step) begin
      step_d = step_q + 1'b1;
      if (op_q == OP_DIV) begin
        if (!diff[DataW+1]) begin
          acc_d = diff[DataW:0];
          wa_d  = {wa_q[DataW-2:0], 1'b1};
        end else begin
          acc_d = rem_sh;
          wa_d  = {wa_q[DataW-2:0], 1'b0};
        end
      end else begin
        if (wb_q[0]) begin
          acc_d = {1'b0, acc_q[DataW-1:0] + wa_q};
        end
        wa_d = {wa_q[DataW-2:0], 1'b0};
        wb_d = {1'b0, wb_q[DataW-1:1]};
      end
    end

    if (cmd_i.load) begin
      res_d.divide_error = 1'b0;
      unique case (op_q)
        OP_ADD: res_d.result_value = first_q + second_q;
        OP_SUB: res_d.result_value = first_q - second_q;
        OP_MUL: res_d.result_value = acc_q[DataW-1:0];
        OP_DIV: begin
          if (second_q == '0) begin
            res_d.result_value = '0;
            res_d.divide_error = 1'b1;
          end else begin
            res_d.result_value = wa_q;
          end
        end
        default: res_d.result_value = '0;
      endcase
    end
  end

endmodule

// File: hdl/keypad_decimal_calculator_unit.sv
// Top level of the keypad decimal calculator: controller plus datapath.
//
//   Channel  Direction  Beat payload                           Handshake
//   in       input      key_t {command, digit_value}           in_valid_i / in_ready_o
//   out      output     result_t {result_value, divide_error}  out_valid_o / out_ready_i
//
// A digit, operator or clear key is accepted while the unit is idle.
// An equals key starts the operation, which steps through the shared shift-add and
// restoring-divide unit before the result register is loaded.
// Keys are accepted while a finished result waits; beyond the calculation the unit
// holds only when a new result is ready and the previous one has not been taken.
// Reset is asynchronous and leaves the calculator off until the on/clear key.
module keypad_decimal_calculator_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kdc_pkg::key_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kdc_pkg::result_t out_data_o
);
  import kdc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .key_i       (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  kdc_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .key_i    (in_data_i),
    .stat_o   (stat),
    .result_o (out_data_o)
  );

endmodule
